FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the local branch predictor.
// Each macro expects signals named clk and rst_n in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define LBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the following edge.
`define LBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lbp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbp_pkg
// Sizes, entry layout and helpers for the two-level local branch predictor.
// ---------------------------------------------------------------------------
package lbp_pkg;

    // Table geometry
    localparam int ENTRIES         = 64;
    localparam int MISS_COUNT_BITS = 16;
    localparam int IDX_W           = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Fixed field widths
    localparam int IN_INDEX_W = 6;
    localparam int OUT_MISS_W = 16;
    localparam int HIST_W     = 2;
    localparam int CTR_W      = 2;
    localparam int PATTERNS   = 4;

    // Two-bit counter codes
    localparam logic [CTR_W-1:0] CTR_MIN       = 2'd0;
    localparam logic [CTR_W-1:0] CTR_TAKEN_MIN = 2'd2;
    localparam logic [CTR_W-1:0] CTR_MAX       = 2'd3;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [MISS_COUNT_BITS-1:0]       miss;
        logic [PATTERNS-1:0][CTR_W-1:0]   ctrs;
        logic [HIST_W-1:0]                hist;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Outcome of one lookup and update
    typedef struct packed {
        logic   predict;
        logic   miss;
        entry_t entry;
    } result_t;

    // Fold an incoming index onto the table
    function automatic logic [IDX_W-1:0] entry_of(input logic [IN_INDEX_W-1:0] raw);
        logic [31:0] wide;
        wide = 32'(raw) % ENTRIES;
        return wide[IDX_W-1:0];
    endfunction

    // Low bits of the miss count as reported on the port
    function automatic logic [OUT_MISS_W-1:0] miss_field(
        input logic [MISS_COUNT_BITS-1:0] m
    );
        logic [63:0] wide;
        wide = 64'(m);
        return wide[OUT_MISS_W-1:0];
    endfunction

endpackage

FILE: rtl/core/lbp_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbp_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on request, register read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/lbp_update.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbp_update
// Prediction and next-state logic for one table entry.
// ---------------------------------------------------------------------------
module lbp_update (
    input  lbp_pkg::entry_t  entry,
    input  logic             taken,
    output lbp_pkg::result_t result
);

    logic [lbp_pkg::CTR_W-1:0] cnt;
    logic [lbp_pkg::CTR_W-1:0] cnt_next;
    logic                      predict;
    logic                      miss;

    // Pick the counter selected by the local history
    assign cnt     = entry.ctrs[entry.hist];
    assign predict = (cnt >= lbp_pkg::CTR_TAKEN_MIN);
    assign miss    = (predict != taken);

    // Step the counter within its bounds
    always_comb
    begin
        cnt_next = cnt;
        if (taken)
        begin
            if (cnt != lbp_pkg::CTR_MAX)
            begin
                cnt_next = cnt + 2'd1;
            end
        end
        else if (cnt != lbp_pkg::CTR_MIN)
        begin
            cnt_next = cnt - 2'd1;
        end
    end

    // Build the updated entry
    always_comb
    begin
        result.predict          = predict;
        result.miss             = miss;
        result.entry            = entry;
        result.entry.ctrs[entry.hist] = cnt_next;
        result.entry.hist       = {entry.hist[0], taken};
        if (miss && (entry.miss != '1))
        begin
            result.entry.miss = entry.miss + 1'b1;
        end
    end

endmodule

FILE: rtl/core/two_level_local_branch_predictor_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_level_local_branch_predictor_top
// Local-history branch predictor table with per-entry saturating counters
// and misprediction totals, held in one synchronous RAM.
// ---------------------------------------------------------------------------
//  Channel   Handshake        Payload
//  request   start / busy     entry_index, actual_taken
//  result    done (strobe)    predicted_taken, mispredicted, entry_miss_count,
//                             history_after, counter_after_nn/nt/tn/tt
//
//  Each item runs as the RAM read in the accept cycle, then the update and
//  write-back; done pulses in the cycle after the write-back.
//  busy is high for one cycle after each transfer, set by the RAM's
//  read-modify-write of a single entry. Reset clears per-entry valid bits at
//  once; an entry not yet written reads as all zero. No clearing pass.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module two_level_local_branch_predictor_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [lbp_pkg::IN_INDEX_W-1:0] entry_index,
    input  logic                           actual_taken,
    output logic                           done,
    output logic                           predicted_taken,
    output logic                           mispredicted,
    output logic [lbp_pkg::OUT_MISS_W-1:0] entry_miss_count,
    output logic [lbp_pkg::HIST_W-1:0]     history_after,
    output logic [lbp_pkg::CTR_W-1:0]      counter_after_nn,
    output logic [lbp_pkg::CTR_W-1:0]      counter_after_nt,
    output logic [lbp_pkg::CTR_W-1:0]      counter_after_tn,
    output logic [lbp_pkg::CTR_W-1:0]      counter_after_tt
);

    `include "assert_macros.svh"

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t                        state_reg;
    logic [lbp_pkg::IDX_W-1:0]     idx_reg;
    logic                          taken_reg;
    logic                          done_reg;
    logic                          predict_reg;
    logic                          miss_reg;
    lbp_pkg::entry_t               entry_out_reg;
    logic [lbp_pkg::ENTRIES-1:0]   valid_reg;

    logic                          accept;
    logic [lbp_pkg::IDX_W-1:0]     idx_in;
    logic [lbp_pkg::ENTRY_W-1:0]   rdata;
    logic                          wr_en;
    lbp_pkg::entry_t               entry_rd;
    lbp_pkg::result_t              result;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign idx_in = lbp_pkg::entry_of(entry_index);
    assign wr_en  = (state_reg == ST_UPDATE);

    // Entry store
    lbp_ram #(
        .WIDTH (lbp_pkg::ENTRY_W),
        .DEPTH (lbp_pkg::ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (idx_reg),
        .wdata (result.entry),
        .re    (accept),
        .raddr (idx_in),
        .rdata (rdata)
    );

    // Treat a never-written entry as cleared
    assign entry_rd = valid_reg[idx_reg] ? lbp_pkg::entry_t'(rdata) : '0;

    lbp_update u_update (
        .entry  (entry_rd),
        .taken  (taken_reg),
        .result (result)
    );

    // Mark entries once written back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    // Sequence the read-modify-write and hold the result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            taken_reg     <= 1'b0;
            done_reg      <= 1'b0;
            predict_reg   <= 1'b0;
            miss_reg      <= 1'b0;
            entry_out_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= ST_UPDATE;
                        idx_reg   <= idx_in;
                        taken_reg <= actual_taken;
                    end
                end
                ST_UPDATE:
                begin
                    state_reg     <= ST_IDLE;
                    done_reg      <= 1'b1;
                    predict_reg   <= result.predict;
                    miss_reg      <= result.miss;
                    entry_out_reg <= result.entry;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    // Drive the result ports
    assign done             = done_reg;
    assign predicted_taken  = predict_reg;
    assign mispredicted     = miss_reg;
    assign entry_miss_count = lbp_pkg::miss_field(entry_out_reg.miss);
    assign history_after    = entry_out_reg.hist;
    assign counter_after_nn = entry_out_reg.ctrs[0];
    assign counter_after_nt = entry_out_reg.ctrs[1];
    assign counter_after_tn = entry_out_reg.ctrs[2];
    assign counter_after_tt = entry_out_reg.ctrs[3];

    // Every transfer yields a result, through the update state and then the done register
    `LBP_ASSERT(a_result_follows, accept |-> ##2 done, "accepted item gave no result")
    // The result strobe never overlaps a read-modify-write
    `LBP_ASSERT(a_done_idle, done |-> !busy, "result shown while busy")
    // A write-back is always followed by the result strobe
    `LBP_ASSERT_NEXT(a_write_done, wr_en, done && !busy, "write-back without result")
    // The miss flag matches the outcome that came with the item
    `LBP_ASSERT(a_miss_flag, done |-> (mispredicted == (predicted_taken != taken_reg)),
        "miss flag disagrees with outcome")

endmodule
